[hdl/bdlp_pkg.sv]
// Shared types, constants and register codes for the button debounce block.
`default_nettype none
package bdlp_pkg;

  localparam int IDX_W  = 2;
  localparam int DT_W   = 16;
  localparam int CFG_W  = 16;
  localparam int TIME_W = 32;

  localparam int NUM_BUTTONS_DEFAULT = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_MS_RESET   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_MS_RESET = 16'd3000;
  localparam logic [CFG_W-1:0] REPEAT_MS_RESET     = 16'd500;

  localparam logic [IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS_MS = 2'd1;
  localparam logic [IDX_W-1:0] REG_REPEAT_MS     = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] button_index;
    logic [DT_W-1:0]  elapsed_ms;
    logic             raw_pressed;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] button_echo;
    logic             press_event;
    logic             release_event;
    logic             long_press_event;
    logic             repeat_event;
    logic             level_now;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0] button_index;
    logic [DT_W-1:0]  elapsed_ms;
    logic             raw_pressed;
    logic             in_range;
    logic             tick;
  } cmd_t;

endpackage
`default_nettype wire

[hdl/bdlp_front.sv]
// Input side: takes sample transfers and tags each one with its class.
`default_nettype none
module bdlp_front #(
  parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bdlp_pkg::in_t in_data,
  input  wire logic          queue_full,
  output logic               push,
  output bdlp_pkg::cmd_t     push_data
);

  localparam int RANGE_W = ($clog2(NUM_BUTTONS + 1) > bdlp_pkg::IDX_W) ?
                           $clog2(NUM_BUTTONS + 1) : bdlp_pkg::IDX_W;
  localparam logic [RANGE_W-1:0] LIMIT = RANGE_W'(NUM_BUTTONS);

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_data.button_index = in_data.button_index;
    push_data.elapsed_ms   = in_data.elapsed_ms;
    push_data.raw_pressed  = in_data.raw_pressed;
    push_data.in_range     = RANGE_W'(in_data.button_index) < LIMIT;
    push_data.tick         = in_data.elapsed_ms != '0;
  end

endmodule
`default_nettype wire

[hdl/bdlp_queue.sv]
// Short queue of classified samples between the input side and the state update.
`default_nettype none
module bdlp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bdlp_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output bdlp_pkg::cmd_t      pop_data,
  output logic                empty
);

  localparam int DEPTH = bdlp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bdlp_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/bdlp_back.sv]
// State update: per-button debounce, hold and repeat logic, with the output register.
`default_nettype none
module bdlp_back #(
  parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [bdlp_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [bdlp_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                         queue_empty,
  input  wire bdlp_pkg::cmd_t               head,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output bdlp_pkg::out_t                    out_data
);

  localparam int IDX_SPAN = 1 << bdlp_pkg::IDX_W;
  localparam int DEPTH    = (NUM_BUTTONS < IDX_SPAN) ? NUM_BUTTONS : IDX_SPAN;
  localparam int SEL_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW       = bdlp_pkg::TIME_W;
  localparam int DW       = bdlp_pkg::DT_W;
  localparam int CW       = bdlp_pkg::CFG_W;

  logic [CW-1:0] debounce_ms;
  logic [CW-1:0] long_press_ms;
  logic [CW-1:0] repeat_ms;

  logic          debounced_level      [DEPTH];
  logic [DW-1:0] debounce_left        [DEPTH];
  logic [TW-1:0] hold_time            [DEPTH];
  logic [TW-1:0] next_repeat_deadline [DEPTH];
  logic          long_press_seen      [DEPTH];

  logic [SEL_W-1:0] sel;
  logic             active;
  logic             cur_level;
  logic [DW-1:0]    cur_left;
  logic [TW-1:0]    cur_hold;
  logic [TW-1:0]    cur_deadline;
  logic             cur_seen;
  logic [DW-1:0]    left_dec;
  logic             expired;
  logic             change;
  logic             held;
  logic [TW:0]      hold_sum;
  logic [TW-1:0]    hold_sat;
  logic [TW:0]      deadline_sum;
  logic [TW-1:0]    deadline_sat;
  logic             lp_fire;
  logic             rep_fire;
  bdlp_pkg::out_t   result;

  assign pop    = !queue_empty && (!out_valid || !out_stall);
  assign sel    = head.button_index[SEL_W-1:0];
  assign active = pop && head.in_range && head.tick;

  always_comb begin
    cur_level    = debounced_level[sel];
    cur_left     = debounce_left[sel];
    cur_hold     = hold_time[sel];
    cur_deadline = next_repeat_deadline[sel];
    cur_seen     = long_press_seen[sel];

    left_dec = (cur_left > head.elapsed_ms) ? cur_left - head.elapsed_ms : '0;
    expired  = left_dec == '0;
    change   = expired && (head.raw_pressed != cur_level);
    held     = expired && !change && head.raw_pressed;

    hold_sum     = {1'b0, cur_hold} + {{(TW + 1 - DW){1'b0}}, head.elapsed_ms};
    hold_sat     = hold_sum[TW] ? {TW{1'b1}} : hold_sum[TW-1:0];
    deadline_sum = {1'b0, cur_deadline} + {{(TW + 1 - CW){1'b0}}, repeat_ms};
    deadline_sat = deadline_sum[TW] ? {TW{1'b1}} : deadline_sum[TW-1:0];

    lp_fire  = !cur_seen && (hold_sat >= {{(TW - CW){1'b0}}, long_press_ms});
    rep_fire = hold_sat >= cur_deadline;

    result.button_echo      = head.button_index;
    result.press_event      = active && change && head.raw_pressed;
    result.release_event    = active && change && !head.raw_pressed;
    result.long_press_event = active && held && lp_fire;
    result.repeat_event     = active && held && rep_fire;
    if (!head.in_range) begin
      result.level_now = 1'b0;
    end else if (active && change) begin
      result.level_now = head.raw_pressed;
    end else begin
      result.level_now = cur_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= bdlp_pkg::DEBOUNCE_MS_RESET;
      long_press_ms <= bdlp_pkg::LONG_PRESS_MS_RESET;
      repeat_ms     <= bdlp_pkg::REPEAT_MS_RESET;
      for (int i = 0; i < DEPTH; i++) begin
        debounced_level[i]      <= 1'b0;
        debounce_left[i]        <= '0;
        hold_time[i]            <= '0;
        next_repeat_deadline[i] <= TW'(bdlp_pkg::REPEAT_MS_RESET);
        long_press_seen[i]      <= 1'b0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          bdlp_pkg::REG_DEBOUNCE_MS: begin
            debounce_ms <= cfg_data;
          end
          bdlp_pkg::REG_LONG_PRESS_MS: begin
            long_press_ms <= cfg_data;
          end
          bdlp_pkg::REG_REPEAT_MS: begin
            repeat_ms <= cfg_data;
            for (int i = 0; i < DEPTH; i++) begin
              next_repeat_deadline[i] <= TW'(cfg_data);
            end
          end
          default: begin
          end
        endcase
      end
      if (active) begin
        debounce_left[sel] <= change ? debounce_ms : left_dec;
        if (change) begin
          debounced_level[sel] <= head.raw_pressed;
          if (!head.raw_pressed) begin
            hold_time[sel]            <= '0;
            next_repeat_deadline[sel] <= TW'(repeat_ms);
            long_press_seen[sel]      <= 1'b0;
          end
        end else if (held) begin
          hold_time[sel] <= hold_sat;
          if (lp_fire) begin
            long_press_seen[sel] <= 1'b1;
          end
          if (rep_fire) begin
            next_repeat_deadline[sel] <= deadline_sat;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

[hdl/button_debounce_long_press.sv]
// Top level of the button debounce block with long-press and auto-repeat events.
//
// Each input transfer on in_data is one tick sample for one button: its index,
// the milliseconds since the previous tick and the raw level. Every sample gives
// exactly one output transfer on out_data carrying the press, release,
// long-press and repeat flags and the debounced level after the sample.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// debounce_ms, long_press_ms and repeat_ms; cfg_ready is always high, and a
// write of repeat_ms also reloads every button's repeat deadline.
// A sample accepted into the queue is popped by the state update and registered in
// the output register. Throughput is one sample per cycle while out_stall is low,
// set by the per-button read-modify-write in the state update stage.
// A two-entry queue sits between the input side and the state update; in_stall
// rises only when it is full. While out_stall is high the output register holds
// its transfer and the queue absorbs up to two further samples.
// A synchronous reset clears all button state and loads the default register
// values; no clearing pass is needed.
`default_nettype none
module button_debounce_long_press #(
  parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire bdlp_pkg::in_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output bdlp_pkg::out_t                  out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [bdlp_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [bdlp_pkg::CFG_W-1:0] cfg_data
);

  logic           push;
  bdlp_pkg::cmd_t push_data;
  logic           queue_full;
  logic           queue_empty;
  logic           pop;
  bdlp_pkg::cmd_t head;

  assign cfg_ready = 1'b1;

  bdlp_front #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .queue_full(queue_full),
    .push      (push),
    .push_data (push_data)
  );

  bdlp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (queue_full),
    .pop      (pop),
    .pop_data (head),
    .empty    (queue_empty)
  );

  bdlp_back #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_empty(queue_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

[hdl/bdlp_checker.sv]
// Port-level checks on the button debounce block and their binding to the top level.
`default_nettype none
module bdlp_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire bdlp_pkg::out_t             out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Output transfer changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Output valid or input stall after reset.");

  a_edge_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.press_event || out_data.release_event) |->
      !(out_data.press_event && out_data.release_event) &&
      (out_data.level_now == out_data.press_event))
    else $error("Press or release flag disagrees with debounced level.");

  a_hold_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.long_press_event || out_data.repeat_event) |->
      out_data.level_now && !out_data.press_event && !out_data.release_event)
    else $error("Hold event without a steady press.");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (.*);
`default_nettype wire

[tb/sv/debounce_event_checker.sv]
// Watches the sample, event and register channels, predicts each button event and checks it.
module debounce_event_checker #(
  parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  bdlp_pkg::in_t              in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  bdlp_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [bdlp_pkg::IDX_W-1:0] cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         expected_left,
  output int                         results_checked,
  output int                         press_count,
  output int                         release_count,
  output int                         long_press_count,
  output int                         repeat_count
);
  import bdlp_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [CFG_W-1:0]  cfg_debounce;
  logic [CFG_W-1:0]  cfg_long;
  logic [CFG_W-1:0]  cfg_repeat;
  logic              btn_level    [NUM_BUTTONS];
  logic [CFG_W-1:0]  lockout_left [NUM_BUTTONS];
  logic [TIME_W-1:0] held_ms      [NUM_BUTTONS];
  logic [TIME_W-1:0] repeat_due   [NUM_BUTTONS];
  logic              long_fired   [NUM_BUTTONS];

  out_t expected_events[$];
  int   errs = 0;
  int   checked = 0;
  int   presses = 0;
  int   releases = 0;
  int   longs = 0;
  int   repeats = 0;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    sat_add = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  endfunction

  function automatic out_t next_events(input in_t s);
    out_t r;
    int unsigned b;
    r = '0;
    b = 32'(s.button_index);
    r.button_echo = s.button_index;
    if (b < NUM_BUTTONS) begin
      if (s.elapsed_ms != '0) begin
        if (lockout_left[b] != '0) begin
          lockout_left[b] = (lockout_left[b] > s.elapsed_ms) ?
                            lockout_left[b] - s.elapsed_ms : '0;
        end
        if (lockout_left[b] == '0) begin
          if (s.raw_pressed != btn_level[b]) begin
            if (s.raw_pressed) begin
              r.press_event = 1'b1;
            end else begin
              r.release_event = 1'b1;
              held_ms[b] = '0;
              repeat_due[b] = TIME_W'(cfg_repeat);
              long_fired[b] = 1'b0;
            end
            lockout_left[b] = cfg_debounce;
            btn_level[b] = s.raw_pressed;
          end else if (s.raw_pressed) begin
            held_ms[b] = sat_add(held_ms[b], TIME_W'(s.elapsed_ms));
            if (!long_fired[b] && held_ms[b] >= TIME_W'(cfg_long)) begin
              long_fired[b] = 1'b1;
              r.long_press_event = 1'b1;
            end
            if (held_ms[b] >= repeat_due[b]) begin
              repeat_due[b] = sat_add(repeat_due[b], TIME_W'(cfg_repeat));
              r.repeat_event = 1'b1;
            end
          end
        end
      end
      r.level_now = btn_level[b];
    end
    next_events = r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      cfg_debounce = DEBOUNCE_MS_RESET;
      cfg_long = LONG_PRESS_MS_RESET;
      cfg_repeat = REPEAT_MS_RESET;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_level[i] = 1'b0;
        lockout_left[i] = '0;
        held_ms[i] = '0;
        repeat_due[i] = TIME_W'(REPEAT_MS_RESET);
        long_fired[i] = 1'b0;
      end
      expected_events.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS) begin
            $display("Unexpected event transfer for button %0d with nothing pending.",
                     out_data.button_echo);
          end
        end else begin
          want = expected_events.pop_front();
          if (out_data !== want) begin
            errs++;
            if (errs <= MAX_REPORTS) begin
              $display("Mismatch: expected echo=%0d press=%b release=%b long=%b repeat=%b level=%b",
                       want.button_echo, want.press_event, want.release_event,
                       want.long_press_event, want.repeat_event, want.level_now);
              $display("          actual   echo=%0d press=%b release=%b long=%b repeat=%b level=%b",
                       out_data.button_echo, out_data.press_event, out_data.release_event,
                       out_data.long_press_event, out_data.repeat_event, out_data.level_now);
            end
          end
          checked++;
        end
        presses += int'(out_data.press_event);
        releases += int'(out_data.release_event);
        longs += int'(out_data.long_press_event);
        repeats += int'(out_data.repeat_event);
      end
      if (in_valid && !in_stall) begin
        expected_events.push_back(next_events(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE_MS: cfg_debounce = cfg_data;
          REG_LONG_PRESS_MS: cfg_long = cfg_data;
          REG_REPEAT_MS: begin
            cfg_repeat = cfg_data;
            for (int i = 0; i < NUM_BUTTONS; i++) repeat_due[i] = TIME_W'(cfg_data);
          end
          default: ;
        endcase
      end
    end
    mismatches <= errs;
    expected_left <= expected_events.size();
    results_checked <= checked;
    press_count <= presses;
    release_count <= releases;
    long_press_count <= longs;
    repeat_count <= repeats;
  end

endmodule

[tb/sv/tb_button_debounce_long_press.sv]
// Stimulus and verdict for the button debounce block with long-press and auto-repeat events.
module tb_button_debounce_long_press;
  import bdlp_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int PHASE_ITEMS = 140;
  localparam int SOAK_ITEMS = 12;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_t              in_data;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int mismatches;
  int expected_left;
  int results_checked;
  int press_count;
  int release_count;
  int long_press_count;
  int repeat_count;

  int send_idle_pct;
  int recv_idle_pct;
  logic holdoff_go = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int held_off_cycles = 0;
  int samples_sent = 0;
  int reg_writes = 0;
  logic [CFG_W-1:0] cur_debounce;
  logic [CFG_W-1:0] cur_repeat;

  button_debounce_long_press dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  debounce_event_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .expected_left(expected_left),
    .results_checked(results_checked), .press_count(press_count),
    .release_count(release_count), .long_press_count(long_press_count),
    .repeat_count(repeat_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (holdoff_go) hold_left = HOLDOFF_CYCLES;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_stall) held_off_cycles++;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d events outstanding.",
               cycle_count, expected_left);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_sample(input logic [IDX_W-1:0] btn, input logic [DT_W-1:0] dt,
                             input logic raw);
    in_t s;
    s.button_index = btn;
    s.elapsed_ms = dt;
    s.raw_pressed = raw;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_DEBOUNCE_MS: cur_debounce = val;
      REG_REPEAT_MS: cur_repeat = val;
      default: ;
    endcase
  endtask

  function automatic logic [DT_W-1:0] pick_elapsed();
    int unsigned sel;
    int unsigned hi;
    sel = $urandom_range(99);
    if (sel < 4) begin
      pick_elapsed = '0;
    end else if (sel < 34) begin
      pick_elapsed = DT_W'($urandom_range(40, 1));
    end else if (sel < 59) begin
      hi = cur_debounce + 1;
      if (hi > 65535) hi = 65535;
      pick_elapsed = DT_W'($urandom_range(hi, 1));
    end else if (sel < 84) begin
      hi = 2 * cur_repeat + 1;
      if (hi > 65535) hi = 65535;
      pick_elapsed = DT_W'($urandom_range(hi, 1));
    end else if (sel < 94) begin
      pick_elapsed = DT_W'($urandom_range(65535, 1));
    end else if (sel < 97) begin
      pick_elapsed = '1;
    end else begin
      pick_elapsed = DT_W'($urandom);
    end
  endfunction

  // Mostly press-and-hold bursts with some contact bounce, then a release, mixed with
  // stray samples on any button.
  task automatic run_random(input int n);
    int sent;
    int len;
    logic [IDX_W-1:0] btn;
    sent = 0;
    while (sent < n) begin
      btn = IDX_W'($urandom_range(3));
      if ($urandom_range(99) < 75) begin
        len = $urandom_range(14, 3);
        for (int k = 0; k < len; k++) send_sample(btn, pick_elapsed(), $urandom_range(99) >= 8);
        sent += len;
        len = $urandom_range(4, 1);
        for (int k = 0; k < len; k++) send_sample(btn, pick_elapsed(), $urandom_range(99) < 8);
        sent += len;
      end else begin
        send_sample(btn, pick_elapsed(), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [IDX_W-1:0] soak_btn;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_debounce = DEBOUNCE_MS_RESET;
    cur_repeat = REPEAT_MS_RESET;
    send_idle_pct = 18;
    recv_idle_pct = 70;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_sample(2'd0, 16'd1, 1'b1);
    send_sample(2'd0, 16'd0, 1'b1);
    send_sample(2'd0, 16'd49, 1'b0);
    send_sample(2'd0, 16'd1, 1'b0);
    send_sample(2'd1, 16'hFFFF, 1'b1);
    send_sample(2'd1, 16'hFFFF, 1'b1);
    send_sample(2'd1, 16'hAAAA, 1'b1);
    send_sample(2'd2, 16'h5555, 1'b1);
    send_sample(2'd2, 16'd50, 1'b1);
    send_sample(2'd2, 16'd450, 1'b1);
    send_sample(2'd2, 16'd2500, 1'b1);
    send_sample(2'd3, 16'd1, 1'b0);
    send_sample(2'd3, 16'd1, 1'b1);
    send_sample(2'd3, 16'd1, 1'b0);
    send_sample(2'd1, 16'd1, 1'b0);
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_REPEAT_MS, 16'd0);
    send_sample(2'd2, 16'd1, 1'b1);
    send_sample(2'd2, 16'd1, 1'b1);
    send_sample(2'd2, 16'hFFFF, 1'b0);

    write_reg(REG_DEBOUNCE_MS, 16'd20);
    write_reg(REG_LONG_PRESS_MS, 16'd100);
    write_reg(REG_REPEAT_MS, 16'd30);
    run_random(PHASE_ITEMS);

    send_idle_pct = 70;
    recv_idle_pct <= 18;
    write_reg(REG_DEBOUNCE_MS, 16'd0);
    write_reg(REG_LONG_PRESS_MS, 16'd0);
    write_reg(REG_REPEAT_MS, 16'd1);
    run_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_reg(REG_DEBOUNCE_MS, CFG_W'($urandom_range(200)));
    write_reg(REG_LONG_PRESS_MS, CFG_W'($urandom_range(1000)));
    write_reg(REG_REPEAT_MS, CFG_W'($urandom_range(300, 1)));
    holdoff_go <= 1'b1;
    @(posedge clk);
    holdoff_go <= 1'b0;
    run_random(PHASE_ITEMS);

    // One button held with the longest tick while every register is at its maximum.
    write_reg(REG_DEBOUNCE_MS, 16'hFFFF);
    write_reg(REG_LONG_PRESS_MS, 16'hFFFF);
    write_reg(REG_REPEAT_MS, 16'hFFFF);
    soak_btn = IDX_W'($urandom_range(3));
    send_sample(soak_btn, 16'hFFFF, 1'b0);
    send_sample(soak_btn, 16'hFFFF, 1'b1);
    for (int k = 0; k < SOAK_ITEMS; k++) send_sample(soak_btn, 16'hFFFF, 1'b1);
    send_sample(soak_btn, 16'hFFFF, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d event transfers from %0d samples across %0d register writes.",
             results_checked, samples_sent, reg_writes);
    $display("Saw %0d presses, %0d releases, %0d long presses, %0d repeats; input stalled %0d cycles.",
             press_count, release_count, long_press_count, repeat_count, held_off_cycles);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
hdl/bdlp_pkg.sv
hdl/bdlp_front.sv
hdl/bdlp_queue.sv
hdl/bdlp_back.sv
hdl/button_debounce_long_press.sv
hdl/bdlp_checker.sv
tb/sv/debounce_event_checker.sv
tb/sv/tb_button_debounce_long_press.sv
